FILE: rtl/swt_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the single-wire 8N1 serial transceiver.
// No dependencies; used by swt_core and the top level.
package swt_pkg;

    localparam int unsigned DATA_BITS       = 8;
    localparam int unsigned TICK_W          = 16;
    localparam int unsigned IDX_W           = 4;
    localparam logic [TICK_W-1:0] BIT_TICKS_RESET = 16'd16;
    localparam logic [TICK_W-1:0] BIT_TICKS_MIN   = 16'd2;
    // start + data + stop
    localparam logic [IDX_W-1:0]  TX_LAST_IDX = 4'(DATA_BITS + 1);
    localparam logic [IDX_W-1:0]  RX_LAST_IDX = 4'(DATA_BITS - 1);

    typedef enum logic [5:0] {
        PH_IDLE    = 6'b000001,
        PH_TX      = 6'b000010,
        PH_RX_HALF = 6'b000100,
        PH_RX_DATA = 6'b001000,
        PH_RX_HIGH = 6'b010000,
        PH_RX_STOP = 6'b100000
    } phase_t;

    typedef struct packed {
        logic       func;
        logic [7:0] tx_byte;
        logic       line_in;
    } in_word_t;

    typedef struct packed {
        logic       line_out;
        logic       drive_enable;
        logic [7:0] rx_byte;
        logic       rx_valid;
        logic       busy_res;
        logic       send_refused;
    } out_word_t;

endpackage

FILE: rtl/swt_core.sv
`timescale 1ns / 1ps
// Frame sequencer: phase, tick counter, bit index and shift registers.
// Depends on swt_pkg. Result word is combinational from state, input word and bit_ticks.
module swt_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          step,
    input  swt_pkg::in_word_t             in_word,
    input  logic [swt_pkg::TICK_W-1:0]    bit_ticks,
    output swt_pkg::out_word_t            result
);

    swt_pkg::phase_t                 phase_reg, phase_next;
    logic [swt_pkg::TICK_W-1:0]      tick_reg, tick_next;
    logic [swt_pkg::IDX_W-1:0]       idx_reg, idx_next;
    logic [7:0]                      tx_shift_reg, tx_shift_next;
    logic [7:0]                      rx_shift_reg, rx_shift_next;

    logic [swt_pkg::TICK_W-1:0]      period;
    logic [swt_pkg::TICK_W:0]        tick_inc;
    logic                            rx_started;
    logic [swt_pkg::IDX_W-1:0]       tx_bit_sel;

    assign period = (bit_ticks < swt_pkg::BIT_TICKS_MIN) ? swt_pkg::BIT_TICKS_MIN : bit_ticks;

    always_comb begin
        phase_next    = phase_reg;
        tick_next     = tick_reg;
        idx_next      = idx_reg;
        tx_shift_next = tx_shift_reg;
        rx_shift_next = rx_shift_reg;
        rx_started    = 1'b0;

        result.line_out     = 1'b1;
        result.drive_enable = 1'b0;
        result.rx_byte      = 8'd0;
        result.rx_valid     = 1'b0;
        result.busy_res     = 1'b0;
        result.send_refused = 1'b0;

        if (phase_reg == swt_pkg::PH_IDLE) begin
            if (in_word.func) begin
                phase_next    = swt_pkg::PH_TX;
                tx_shift_next = in_word.tx_byte;
                idx_next      = '0;
                tick_next     = '0;
            end else if (!in_word.line_in) begin
                phase_next    = swt_pkg::PH_RX_HALF;
                rx_shift_next = 8'd0;
                idx_next      = '0;
                tick_next     = '0;
                result.busy_res = 1'b1;
                rx_started    = 1'b1;
            end
        end else if (in_word.func) begin
            result.send_refused = 1'b1;
        end

        tick_inc   = {1'b0, tick_next} + 17'd1;
        tx_bit_sel = idx_next - 4'd1;

        case (phase_next)
            swt_pkg::PH_TX: begin
                result.busy_res     = 1'b1;
                result.drive_enable = 1'b1;
                if (idx_next == '0) begin
                    result.line_out = 1'b0;
                end else if (idx_next <= 4'(swt_pkg::DATA_BITS)) begin
                    result.line_out = tx_shift_next[tx_bit_sel[2:0]];
                end else begin
                    result.line_out = 1'b1;
                end
                if (tick_inc >= {1'b0, period}) begin
                    tick_next = '0;
                    if (idx_next == swt_pkg::TX_LAST_IDX) begin
                        idx_next   = '0;
                        phase_next = swt_pkg::PH_IDLE;
                    end else begin
                        idx_next = idx_next + 4'd1;
                    end
                end else begin
                    tick_next = tick_inc[swt_pkg::TICK_W-1:0];
                end
            end
            swt_pkg::PH_RX_HALF: begin
                // start edge tick itself does not count toward the half-bit wait
                if (!rx_started) begin
                    result.busy_res = 1'b1;
                    if (tick_inc >= {2'b00, period[swt_pkg::TICK_W-1:1]}) begin
                        tick_next  = '0;
                        phase_next = swt_pkg::PH_RX_DATA;
                    end else begin
                        tick_next = tick_inc[swt_pkg::TICK_W-1:0];
                    end
                end
            end
            swt_pkg::PH_RX_DATA: begin
                result.busy_res = 1'b1;
                if (tick_inc >= {1'b0, period}) begin
                    tick_next = '0;
                    rx_shift_next[idx_next[2:0]] = rx_shift_next[idx_next[2:0]] | in_word.line_in;
                    if (idx_next == swt_pkg::RX_LAST_IDX) begin
                        idx_next   = '0;
                        phase_next = swt_pkg::PH_RX_HIGH;
                    end else begin
                        idx_next = idx_next + 4'd1;
                    end
                end else begin
                    tick_next = tick_inc[swt_pkg::TICK_W-1:0];
                end
            end
            swt_pkg::PH_RX_HIGH: begin
                result.busy_res = 1'b1;
                if (in_word.line_in) begin
                    tick_next  = '0;
                    phase_next = swt_pkg::PH_RX_STOP;
                end
            end
            swt_pkg::PH_RX_STOP: begin
                result.busy_res = 1'b1;
                if (tick_inc >= {1'b0, period}) begin
                    tick_next       = '0;
                    result.rx_valid = 1'b1;
                    result.rx_byte  = rx_shift_next;
                    phase_next      = swt_pkg::PH_IDLE;
                end else begin
                    tick_next = tick_inc[swt_pkg::TICK_W-1:0];
                end
            end
            default: begin
                // idle with no request and a high line: nothing happens
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= swt_pkg::PH_IDLE;
            tick_reg     <= '0;
            idx_reg      <= '0;
            tx_shift_reg <= '0;
            rx_shift_reg <= '0;
        end else if (step) begin
            phase_reg    <= phase_next;
            tick_reg     <= tick_next;
            idx_reg      <= idx_next;
            tx_shift_reg <= tx_shift_next;
            rx_shift_reg <= rx_shift_next;
        end
    end

endmodule

FILE: rtl/single_wire_serial_8n1_transceiver.sv
`timescale 1ns / 1ps
// Single-wire 8N1 serial transceiver, one tick per input word.
// The result word is registered and appears on m_ in the cycle after its input word is accepted.
// Throughput: one word per cycle while m_ready keeps up; the output register frees itself when m_ready is high.
// Reset (aresetn, synchronous, active low): idle phase, counters and shifters cleared,
// bit_ticks back to 16, output register empty.
// Depends on swt_pkg and swt_core.
module single_wire_serial_8n1_transceiver (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  swt_pkg::in_word_t           s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output swt_pkg::out_word_t          m_data,
    input  logic                        cfg_we,
    input  logic [swt_pkg::TICK_W-1:0]  cfg_wdata
);

    logic [swt_pkg::TICK_W-1:0] bit_ticks_reg;
    logic                       m_valid_reg, m_valid_next;
    swt_pkg::out_word_t         m_data_reg;
    swt_pkg::out_word_t         result;
    logic                       accept;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    swt_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (accept),
        .in_word   (s_data),
        .bit_ticks (bit_ticks_reg),
        .result    (result)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_ticks_reg <= swt_pkg::BIT_TICKS_RESET;
            m_valid_reg   <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                bit_ticks_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= result;
        end
    end

endmodule
